### hdl/rpp_pkg.sv
// Shared types, widths and helpers for the ray point projection unit.
package rpp_pkg;

  // Field and datapath widths.
  localparam int unsigned WordW  = 32;
  localparam int unsigned PoW    = 33;
  localparam int unsigned ProdW  = 65;
  localparam int unsigned DotW   = 67;
  localparam int unsigned DotMW  = 66;
  localparam int unsigned NumW   = 97;
  localparam int unsigned QuotW  = 35;
  localparam int unsigned SqW    = 64;
  localparam int unsigned LineW  = 37;
  localparam int unsigned MagW   = 36;
  localparam int unsigned SqrW   = 72;
  localparam int unsigned SumW   = 74;
  localparam int unsigned RootW  = 32;
  localparam int unsigned RremW  = 35;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [PoW-1:0]   po_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [DotW-1:0]  dot_t;
  typedef logic signed [LineW-1:0] line_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } reg_idx_e;

  // One classified point handed from the front end to the back end.
  typedef struct packed {
    po_t [2:0] po;
    dot_t      dot;
  } fq_item_t;

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic word_t sat32(input line_t v);
    word_t r;
    if (v > $signed(LineW'(32'h7FFFFFFF))) begin
      r = word_t'(32'h7FFFFFFF);
    end else if (v < -$signed(LineW'(33'h080000000))) begin
      r = word_t'(32'h80000000);
    end else begin
      r = v[WordW-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/rpp_front.sv
// Front end: takes points, forms P - O and the dot product with the direction.
module rpp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [95:0]            s_tdata_i,
  input  rpp_pkg::word_t [2:0]   origin_i,
  input  rpp_pkg::word_t [2:0]   dir_i,
  output logic                   push_o,
  output rpp_pkg::fq_item_t      item_o,
  input  logic                   full_i
);
  import rpp_pkg::*;

  logic  v1_q, v2_q, v3_q;
  logic  en;
  po_t   po1_q [3];
  po_t   po2_q [3];
  po_t   po3_q [3];
  prod_t prod_q [3];
  dot_t  dot_q;

  // The three stages move together unless the last one holds a point the queue cannot take.
  assign en         = ~v3_q | ~full_i;
  assign s_tready_o = en;
  assign push_o     = v3_q & ~full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Offset from the origin, per-axis products, then their sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        po1_q[i]  <= $signed({s_tdata_i[32*i+31], s_tdata_i[32*i+:32]})
                     - $signed({origin_i[i][WordW-1], origin_i[i]});
        prod_q[i] <= po1_q[i] * $signed(dir_i[i]);
        po2_q[i]  <= po1_q[i];
        po3_q[i]  <= po2_q[i];
      end
      dot_q <= DotW'(prod_q[0]) + DotW'(prod_q[1]) + DotW'(prod_q[2]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item_o.po[i] = po3_q[i];
    end
    item_o.dot = dot_q;
  end

endmodule

### hdl/rpp_queue.sv
// Short queue between the front end and the back end.
module rpp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rpp_pkg::fq_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output rpp_pkg::fq_item_t item_o,
  output logic              empty_o
);
  import rpp_pkg::*;

  fq_item_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

### hdl/rpp_back.sv
// Back end: scales the direction, divides by |D|^2, forms results and the square root.
module rpp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpp_pkg::word_t [2:0]  origin_i,
  input  rpp_pkg::word_t [2:0]  dir_i,
  input  logic                  empty_i,
  input  rpp_pkg::fq_item_t     item_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output rpp_pkg::word_t [2:0]  proj_o,
  output rpp_pkg::word_t [2:0]  perp_o,
  output logic [63:0]           sq_distance_o,
  output logic [31:0]           distance_o,
  output logic                  dir_zero_o
);
  import rpp_pkg::*;

  localparam int unsigned DivN  = QuotW;
  localparam int unsigned SqrtN = RootW;

  logic en;

  // Direction magnitudes and |D|^2, kept current from the registers.
  logic [WordW-1:0] dmag_q [3];
  logic [SqW-1:0]   dsq_q  [3];
  logic [SqW-1:0]   sq_q;

  // Entry stages.
  logic             v0_q, v1_q;
  logic [DotMW-1:0] dm0_q;
  logic             dn0_q;
  po_t              po0_q [3];
  po_t              po1_q [3];
  logic [ProdW-1:0] lo1_q [3];
  logic [ProdW-1:0] hi1_q [3];
  logic             qn1_q [3];
  logic [NumW-1:0]  num_w [3];

  // Divider stages.
  logic             dv_q  [DivN+1];
  logic [SqW-1:0]   dr_q  [DivN+1][3];
  logic [QuotW-1:0] dl_q  [DivN+1][3];
  logic [QuotW-1:0] dq_q  [DivN+1][3];
  logic             dn_q  [DivN+1][3];
  po_t              dpo_q [DivN+1][3];

  // Result forming stages.
  logic             vq_q, vr_q, vs_q;
  line_t            q_q   [3];
  po_t              poq_q [3];
  word_t            projr_q [3], perpr_q [3];
  logic [MagW-1:0]  pmag_q [3];
  word_t            projs_q [3], perps_q [3];
  logic [SqrW-1:0]  sqr_q  [3];
  logic [SumW-1:0]  sum_w;

  // Square root stages.
  logic             sv_q  [SqrtN+1];
  logic [RremW-1:0] sr_q  [SqrtN+1];
  logic [RootW-1:0] st_q  [SqrtN+1];
  logic [SqW-1:0]   sx_q  [SqrtN+1];
  logic [SqW-1:0]   sd_q  [SqrtN+1];
  word_t            sp_q  [SqrtN+1][3];
  word_t            sq3_q [SqrtN+1][3];

  // Whole back end advances unless the output register holds an untaken result.
  assign en    = ~sv_q[SqrtN] | m_tready_i;
  assign pop_o = en & ~empty_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dmag_q[i] <= dir_i[i][WordW-1] ? (WordW'(0) - dir_i[i]) : dir_i[i];
      dsq_q[i]  <= dmag_q[i] * dmag_q[i];
    end
    sq_q <= dsq_q[0] + dsq_q[1] + dsq_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vq_q <= 1'b0;
      vr_q <= 1'b0;
      vs_q <= 1'b0;
      for (int s = 0; s <= DivN; s++) dv_q[s] <= 1'b0;
      for (int s = 0; s <= SqrtN; s++) sv_q[s] <= 1'b0;
    end else if (en) begin
      v0_q    <= pop_o;
      v1_q    <= v0_q;
      dv_q[0] <= v1_q;
      for (int s = 1; s <= DivN; s++) dv_q[s] <= dv_q[s-1];
      vq_q    <= dv_q[DivN];
      vr_q    <= vq_q;
      vs_q    <= vr_q;
      sv_q[0] <= vs_q;
      for (int s = 1; s <= SqrtN; s++) sv_q[s] <= sv_q[s-1];
    end
  end

  // Numerator |dot| * |D_i| out of two registered partial products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_w[i] = NumW'({hi1_q[i], 33'b0}) + NumW'(lo1_q[i]);
    end
  end

  // Sum of squares of the perpendicular, before saturation.
  assign sum_w = SumW'(sqr_q[0]) + SumW'(sqr_q[1]) + SumW'(sqr_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Magnitude and sign of the dot product.
      dm0_q <= item_i.dot[DotW-1] ? DotMW'(-item_i.dot) : item_i.dot[DotMW-1:0];
      dn0_q <= item_i.dot[DotW-1];
      for (int i = 0; i < 3; i++) begin
        po0_q[i] <= item_i.po[i];
        // Partial products of the numerator.
        lo1_q[i] <= dm0_q[32:0] * dmag_q[i];
        hi1_q[i] <= dm0_q[65:33] * dmag_q[i];
        qn1_q[i] <= dn0_q ^ dir_i[i][WordW-1];
        po1_q[i] <= po0_q[i];
        // Divider load: the quotient stays below 2^35, so the top bits start below |D|^2.
        dr_q[0][i]  <= SqW'(num_w[i][NumW-1:QuotW]);
        dl_q[0][i]  <= num_w[i][QuotW-1:0];
        dq_q[0][i]  <= '0;
        dn_q[0][i]  <= qn1_q[i];
        dpo_q[0][i] <= po1_q[i];
      end

      // Restoring division, one quotient bit per stage.
      for (int s = 1; s <= DivN; s++) begin
        for (int i = 0; i < 3; i++) begin
          if ({dr_q[s-1][i], dl_q[s-1][i][QuotW-1]} >= {1'b0, sq_q}) begin
            dr_q[s][i] <= SqW'({dr_q[s-1][i], dl_q[s-1][i][QuotW-1]} - {1'b0, sq_q});
            dq_q[s][i] <= {dq_q[s-1][i][QuotW-2:0], 1'b1};
          end else begin
            dr_q[s][i] <= SqW'({dr_q[s-1][i], dl_q[s-1][i][QuotW-1]});
            dq_q[s][i] <= {dq_q[s-1][i][QuotW-2:0], 1'b0};
          end
          dl_q[s][i]  <= {dl_q[s-1][i][QuotW-2:0], 1'b0};
          dn_q[s][i]  <= dn_q[s-1][i];
          dpo_q[s][i] <= dpo_q[s-1][i];
        end
      end

      for (int i = 0; i < 3; i++) begin
        // Signed offset along the line; zero for a zero direction.
        if (sq_q == '0) begin
          q_q[i] <= '0;
        end else if (dn_q[DivN][i]) begin
          q_q[i] <= -$signed({2'b00, dq_q[DivN][i]});
        end else begin
          q_q[i] <= $signed({2'b00, dq_q[DivN][i]});
        end
        poq_q[i] <= dpo_q[DivN][i];

        // Projection, perpendicular and its magnitude.
        projr_q[i] <= sat32(LineW'($signed(origin_i[i])) + q_q[i]);
        perpr_q[i] <= sat32(LineW'(poq_q[i]) - q_q[i]);
        if ((LineW'(poq_q[i]) - q_q[i]) < 0) begin
          pmag_q[i] <= MagW'(q_q[i] - LineW'(poq_q[i]));
        end else begin
          pmag_q[i] <= MagW'(LineW'(poq_q[i]) - q_q[i]);
        end

        sqr_q[i]   <= pmag_q[i] * pmag_q[i];
        projs_q[i] <= projr_q[i];
        perps_q[i] <= perpr_q[i];
        sp_q[0][i]  <= projs_q[i];
        sq3_q[0][i] <= perps_q[i];
      end

      // Saturated squared distance enters the root pipeline.
      if (sum_w[SumW-1:SqW] != '0) begin
        sd_q[0] <= '1;
        sx_q[0] <= '1;
      end else begin
        sd_q[0] <= sum_w[SqW-1:0];
        sx_q[0] <= sum_w[SqW-1:0];
      end
      sr_q[0] <= '0;
      st_q[0] <= '0;

      // Integer square root, one root bit per stage.
      for (int s = 1; s <= SqrtN; s++) begin
        if ({sr_q[s-1][RremW-3:0], sx_q[s-1][SqW-1:SqW-2]}
            >= RremW'({st_q[s-1], 2'b01})) begin
          sr_q[s] <= {sr_q[s-1][RremW-3:0], sx_q[s-1][SqW-1:SqW-2]}
                     - RremW'({st_q[s-1], 2'b01});
          st_q[s] <= {st_q[s-1][RootW-2:0], 1'b1};
        end else begin
          sr_q[s] <= {sr_q[s-1][RremW-3:0], sx_q[s-1][SqW-1:SqW-2]};
          st_q[s] <= {st_q[s-1][RootW-2:0], 1'b0};
        end
        sx_q[s] <= {sx_q[s-1][SqW-3:0], 2'b00};
        sd_q[s] <= sd_q[s-1];
        for (int i = 0; i < 3; i++) begin
          sp_q[s][i]  <= sp_q[s-1][i];
          sq3_q[s][i] <= sq3_q[s-1][i];
        end
      end
    end
  end

  // The last root stage is the output register.
  assign m_tvalid_o    = sv_q[SqrtN];
  assign sq_distance_o = sd_q[SqrtN];
  assign distance_o    = st_q[SqrtN];
  assign dir_zero_o    = (sq_q == '0);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      proj_o[i] = sp_q[SqrtN][i];
      perp_o[i] = sq3_q[SqrtN][i];
    end
  end

endmodule

### hdl/ray_point_projection_unit.sv
// Top level of the ray point projection unit.
//
// Usage: the ray origin and direction live in six configuration registers
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i while the unit is idle.
// Points arrive on the slave stream (x, y, z in Q16.16) and one result per
// point leaves on the master stream: projection, perpendicular vector,
// squared distance and distance in tdata, and the zero-direction flag in tuser.
// The back end holds a 35-stage divider and a 32-stage root unit; throughput
// is one point per cycle while the receiver takes every result.
// Reset clears all stage valid flags and the queue, and loads the origin
// with zero and the direction with (1.0, 0, 0).
// When the receiver stalls, the back end freezes with its result held in
// the output register; the front end keeps taking points into a four-entry
// queue and drops tready only when that queue is full.
module ray_point_projection_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // point_x, point_y, point_z
  input  logic [95:0]  s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // proj_x, proj_y, proj_z, perp_x, perp_y, perp_z, sq_distance, distance
  output logic [287:0] m_tdata_o,
  // dir_zero
  output logic         m_tuser_o
);
  import rpp_pkg::*;

  word_t [2:0] origin_q, dir_q;
  logic        push, full, pop, empty;
  fq_item_t    fr_item, bk_item;
  word_t [2:0] proj, perp;
  logic [63:0] sq_distance;
  logic [31:0] distance;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      dir_q    <= {word_t'(0), word_t'(0), word_t'(64'd1 << FRAC_BITS)};
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ORIGIN_X: origin_q[0] <= cfg_wdata_i;
        REG_ORIGIN_Y: origin_q[1] <= cfg_wdata_i;
        REG_ORIGIN_Z: origin_q[2] <= cfg_wdata_i;
        REG_DIR_X:    dir_q[0]    <= cfg_wdata_i;
        REG_DIR_Y:    dir_q[1]    <= cfg_wdata_i;
        REG_DIR_Z:    dir_q[2]    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rpp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .origin_i   (origin_q),
    .dir_i      (dir_q),
    .push_o     (push),
    .item_o     (fr_item),
    .full_i     (full)
  );

  rpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (bk_item),
    .empty_o (empty)
  );

  rpp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .origin_i      (origin_q),
    .dir_i         (dir_q),
    .empty_i       (empty),
    .item_i        (bk_item),
    .pop_o         (pop),
    .m_tvalid_o    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .proj_o        (proj),
    .perp_o        (perp),
    .sq_distance_o (sq_distance),
    .distance_o    (distance),
    .dir_zero_o    (m_tuser_o)
  );

  assign m_tdata_o = {distance, sq_distance, perp[2], perp[1], perp[0],
                      proj[2], proj[1], proj[0]};

endmodule
